// ----- hdl/devreg_pkg.sv -----
// Shared types and constants for the device registry table.
`timescale 1ns / 1ps
package devreg_pkg;

    // Default number of table entries.
    localparam int DEF_MAX_ENTRIES = 64;
    // Width of the index carried by a search token; covers up to 256 entries.
    localparam int HIT_IDX_W = 8;

    // Item selector codes.
    localparam logic [1:0] FN_ADD      = 2'd0;
    localparam logic [1:0] FN_FIND_VD  = 2'd1;
    localparam logic [1:0] FN_FIND_CLS = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [15:0] vendor_tag;
        logic [15:0] device_tag;
        logic [7:0]  base_class;
        logic [7:0]  subclass_code;
    } t_dev_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] entry_index;
        logic [6:0] entry_count;
    } t_dev_rsp;

    // One stored table entry, 64 bits.
    typedef struct packed {
        logic [7:0]  bus_number;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [15:0] vendor_tag;
        logic [15:0] device_tag;
        logic [7:0]  base_class;
        logic [7:0]  subclass_code;
    } t_dev_entry;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic                 by_class;
        logic [15:0]          vendor_tag;
        logic [15:0]          device_tag;
        logic [7:0]           base_class;
        logic [7:0]           subclass_code;
        logic                 hit;
        logic [HIT_IDX_W-1:0] hit_idx;
    } t_dev_tok;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_dev_state;

endpackage

// ----- hdl/device_registry_table_core.sv -----
// Top level of the device registry table: control, fill pointer and cell row.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  request | in        | i_valid / o_ready  | i_item (t_dev_req)
//  result  | out       | o_valid / i_ready  | o_item (t_dev_rsp)
//
//  Add, full and unused-selector items complete without a search: the result is
//  registered at the accept edge. Lookups inject a search token into a row of
//  MAX_ENTRIES cells; the token moves one cell per cycle, and the lookup result
//  is registered when the token leaves the last cell. The row walk sets the rate.
//  One item is in flight at a time; a new item is taken once the result
//  register is empty or being emptied. Synchronous active-low reset clears
//  the fill count, token valids, state and the result valid.
//
module device_registry_table_core #(
    parameter int MAX_ENTRIES = devreg_pkg::DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  devreg_pkg::t_dev_req i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output devreg_pkg::t_dev_rsp o_item
);
    import devreg_pkg::*;

    // Fill count must hold MAX_ENTRIES itself.
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    // Scratch width for reporting count/index modulo the field widths.
    localparam int EXT_W = CNT_W + HIT_IDX_W;

    t_dev_state r_state;
    t_dev_state n_state;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic     r_out_valid;
    logic     n_out_valid;
    t_dev_rsp r_out_item;
    t_dev_rsp n_out_item;

    logic       w_accept;
    logic       w_lookup;
    logic       w_full;
    logic       w_wr_en;
    logic       w_done;
    t_dev_entry w_wr_entry;
    t_dev_tok   w_tok [MAX_ENTRIES+1];

    logic [EXT_W-1:0] w_cnt_ext;
    logic [EXT_W-1:0] w_cnt_inc_ext;
    logic [EXT_W-1:0] w_hit_ext;

    assign w_accept = i_valid && o_ready;
    assign w_lookup = (i_item.func == FN_FIND_VD) || (i_item.func == FN_FIND_CLS);
    assign w_full   = r_count == CNT_W'(MAX_ENTRIES);
    assign w_wr_en  = w_accept && (i_item.func == FN_ADD) && !w_full;

    // Token reaching the end of the row closes the lookup.
    assign w_done = w_tok[MAX_ENTRIES].valid;

    assign w_wr_entry.bus_number      = i_item.bus_number;
    assign w_wr_entry.device_number   = i_item.device_number;
    assign w_wr_entry.function_number = i_item.function_number;
    assign w_wr_entry.vendor_tag      = i_item.vendor_tag;
    assign w_wr_entry.device_tag      = i_item.device_tag;
    assign w_wr_entry.base_class      = i_item.base_class;
    assign w_wr_entry.subclass_code   = i_item.subclass_code;

    // Token entering cell 0.
    assign w_tok[0].valid         = w_accept && w_lookup;
    assign w_tok[0].by_class      = i_item.func == FN_FIND_CLS;
    assign w_tok[0].vendor_tag    = i_item.vendor_tag;
    assign w_tok[0].device_tag    = i_item.device_tag;
    assign w_tok[0].base_class    = i_item.base_class;
    assign w_tok[0].subclass_code = i_item.subclass_code;
    assign w_tok[0].hit           = 1'b0;
    assign w_tok[0].hit_idx       = '0;

    // Row of cells, one entry each.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        devreg_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en),
            .i_count    (r_count),
            .i_wr_entry (w_wr_entry),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_lookup) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake out of state.
    always_comb begin
        case (r_state)
            S_IDLE:   o_ready = !r_out_valid || i_ready;
            S_SEARCH: o_ready = 1'b0;
            default:  o_ready = 1'b0;
        endcase
    end

    // Count and index are reported modulo their field widths.
    assign w_cnt_ext     = EXT_W'(r_count);
    assign w_cnt_inc_ext = EXT_W'(r_count) + EXT_W'(1);
    assign w_hit_ext     = EXT_W'(w_tok[MAX_ENTRIES].hit_idx);

    assign n_count = w_wr_en ? CNT_W'(w_cnt_inc_ext) : r_count;

    // Result register.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept && !w_lookup) begin
            n_out_valid            = 1'b1;
            n_out_item.status      = ST_NOT_FOUND;
            n_out_item.entry_index = '0;
            n_out_item.entry_count = w_cnt_ext[6:0];
            if (i_item.func == FN_ADD) begin
                if (w_full) begin
                    n_out_item.status = ST_FULL;
                end else begin
                    n_out_item.status      = ST_OK;
                    n_out_item.entry_index = w_cnt_ext[5:0];
                    n_out_item.entry_count = w_cnt_inc_ext[6:0];
                end
            end
        end else if (w_done) begin
            n_out_valid            = 1'b1;
            n_out_item.entry_count = w_cnt_ext[6:0];
            if (w_tok[MAX_ENTRIES].hit) begin
                n_out_item.status      = ST_OK;
                n_out_item.entry_index = w_hit_ext[5:0];
            end else begin
                n_out_item.status      = ST_NOT_FOUND;
                n_out_item.entry_index = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ----- hdl/devreg_cell.sv -----
// One table cell: holds an entry and checks the passing search token.
`timescale 1ns / 1ps
module devreg_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CNT_W-1:0]      i_count,
    input  devreg_pkg::t_dev_entry i_wr_entry,
    input  devreg_pkg::t_dev_tok  i_tok,
    output devreg_pkg::t_dev_tok  o_tok
);
    import devreg_pkg::*;

    t_dev_entry r_entry;
    t_dev_tok   r_tok;
    t_dev_tok   n_tok;
    logic       w_filled;
    logic       w_match;

    // Entry is written when the fill pointer lands on this cell.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_count == CNT_W'(IDX))) begin
            r_entry <= i_wr_entry;
        end
    end

    assign w_filled = CNT_W'(IDX) < i_count;

    always_comb begin
        if (i_tok.by_class) begin
            w_match = (r_entry.base_class == i_tok.base_class) &&
                      (r_entry.subclass_code == i_tok.subclass_code);
        end else begin
            w_match = (r_entry.vendor_tag == i_tok.vendor_tag) &&
                      (r_entry.device_tag == i_tok.device_tag);
        end
    end

    // First matching cell claims the token; later cells pass it unchanged.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && w_filled && w_match) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = HIT_IDX_W'(IDX);
        end
    end

    // Only the valid bit is reset; the rest of the token follows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.by_class      <= n_tok.by_class;
        r_tok.vendor_tag    <= n_tok.vendor_tag;
        r_tok.device_tag    <= n_tok.device_tag;
        r_tok.base_class    <= n_tok.base_class;
        r_tok.subclass_code <= n_tok.subclass_code;
        r_tok.hit           <= n_tok.hit;
        r_tok.hit_idx       <= n_tok.hit_idx;
    end

    assign o_tok = r_tok;

endmodule
